### src/bnis_pkg.sv
// Shared types and constants of the bilinear / nearest-neighbor image scaler.
// Used by bnis_blend and the top-level scaler; depends on nothing.
`default_nettype none

package bnis_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_MAX_SRC_WIDTH  = 256;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 256;
  localparam int unsigned DEF_MAX_DST_DIM    = 4096;
  localparam int unsigned DEF_FRAC_BITS      = 16;

  // Fixed field and register widths
  localparam int unsigned SRC_REG_W   = 9;
  localparam int unsigned DST_REG_W   = 13;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned DST_COORD_W = 12;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned CHAN_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd4;

  // Input item actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Neighbor of a bilinear tap: bit 0 selects the right column, bit 1 the lower row
  typedef logic [1:0] corner_t;
  localparam corner_t CORNER_TL = 2'd0;
  localparam corner_t CORNER_BR = 2'd3;

  typedef struct packed {
    logic    wload;   // register the weight of the current corner
    logic    clear;   // zero the channel accumulators
    logic    acc_en;  // add the returned pixel times the held weight
    corner_t corner;
  } blend_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POS,
    ST_COORD,
    ST_FETCH,
    ST_DRAIN,
    ST_PACK,
    ST_SINGLE_RD,
    ST_SINGLE_DAT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### src/bnis_frame_mem.sv
// Single-port synchronous source frame store with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module bnis_frame_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write or read one word per cycle while enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bnis_div.sv
// Restoring divider, one quotient bit per cycle; the scaler uses one per axis for the coordinate math.
// Stand-alone; no package needed.
`default_nettype none

module bnis_div #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    qbit   = ~diff[DEN_W];
    rem_d  = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Hold remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### src/bnis_blend.sv
// Bilinear weight generation and per-channel multiply-accumulate.
// Depends on bnis_pkg for the control struct and channel constants.
`default_nettype none

module bnis_blend #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  bnis_pkg::blend_ctl_t          ctl_i,
  input  logic [FRAC_BITS-1:0]          fx_i,
  input  logic [FRAC_BITS-1:0]          fy_i,
  input  logic [bnis_pkg::PIXEL_W-1:0]  pixel_i,
  output logic [bnis_pkg::PIXEL_W-1:0]  pixel_o
);

  import bnis_pkg::*;

  localparam int unsigned F1_W   = FRAC_BITS + 1;
  localparam int unsigned PROD_W = 2 * F1_W;
  localparam int unsigned W_W    = 2 * FRAC_BITS + 1;
  localparam int unsigned ACC_W  = 2 * FRAC_BITS + CHAN_W;
  localparam int unsigned NCH    = 3;

  logic [F1_W-1:0]   one_c;
  logic [F1_W-1:0]   fa, fb;
  logic [PROD_W-1:0] wprod;
  logic [W_W-1:0]    w_q;
  logic [ACC_W-1:0]  acc_q [NCH];

  // Pick fx or 1-fx, fy or 1-fy by corner and form the weight
  always_comb begin
    one_c = {1'b1, {FRAC_BITS{1'b0}}};
    fa    = ctl_i.corner[0] ? F1_W'(fx_i) : one_c - F1_W'(fx_i);
    fb    = ctl_i.corner[1] ? F1_W'(fy_i) : one_c - F1_W'(fy_i);
    wprod = PROD_W'(fa) * PROD_W'(fb);
  end

  // Hold the weight for the pixel that returns next cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wload) begin
      w_q <= wprod[W_W-1:0];
    end
  end

  // Accumulate blue, green and red
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      if (ctl_i.clear) begin
        acc_q[c] <= '0;
      end else if (ctl_i.acc_en) begin
        acc_q[c] <= acc_q[c] + ACC_W'(pixel_i[c*CHAN_W +: CHAN_W]) * ACC_W'(w_q);
      end
    end
  end

  // Truncate each channel, force alpha opaque
  assign pixel_o = {ALPHA_OPAQUE,
                    acc_q[2][ACC_W-1 -: CHAN_W],
                    acc_q[1][ACC_W-1 -: CHAN_W],
                    acc_q[0][ACC_W-1 -: CHAN_W]};

endmodule

`default_nettype wire

### src/bilinear_nearest_image_scaler.sv
// Image scaler: holds a MAX_SRC_WIDTH x MAX_SRC_HEIGHT frame of ARGB pixels in a
// single-port memory and returns one pixel of the resized image per sample request.
// A sample whose source and destination sizes match copies the stored pixel without
// division. Otherwise a restoring divider that yields one quotient bit per cycle
// sets the pace, with NUM_W = max(21, 9 + FRAC_BITS) (25 by default) quotient bits;
// nearest neighbor then reads one pixel, bilinear four through the one memory port.
// One item is worked on at a time; the finished pixel sits in an output
// register so the next item is taken while it waits to be transferred.
// Depends on bnis_pkg, bnis_frame_mem, bnis_div and bnis_blend.
`default_nettype none

module bilinear_nearest_image_scaler #(
  parameter int unsigned MAX_SRC_WIDTH  = bnis_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bnis_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_DIM    = bnis_pkg::DEF_MAX_DST_DIM,
  parameter int unsigned FRAC_BITS      = bnis_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bnis_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bnis_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [bnis_pkg::COORD_W-1:0]      src_x_i,
  input  logic [bnis_pkg::COORD_W-1:0]      src_y_i,
  input  logic [bnis_pkg::PIXEL_W-1:0]      src_pixel_i,
  input  logic [bnis_pkg::DST_COORD_W-1:0]  dst_x_i,
  input  logic [bnis_pkg::DST_COORD_W-1:0]  dst_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bnis_pkg::PIXEL_W-1:0]      out_pixel_o
);

  import bnis_pkg::*;

  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NUM_W = (DST_COORD_W + SRC_REG_W > SRC_REG_W + FRAC_BITS) ?
                                  DST_COORD_W + SRC_REG_W : SRC_REG_W + FRAC_BITS;
  localparam int unsigned PX_W  = NUM_W + DST_COORD_W;
  localparam int unsigned PI_W  = PX_W - FRAC_BITS;

  // Clamp a coordinate to [0, size-1]
  function automatic logic [SRC_REG_W-1:0] clamp_coord(input logic [PI_W-1:0]      c,
                                                       input logic [SRC_REG_W-1:0] size);
    clamp_coord = (c >= PI_W'(size)) ? size - SRC_REG_W'(1) : SRC_REG_W'(c);
  endfunction

  // Configuration registers
  logic [SRC_REG_W-1:0] src_w_q, src_h_q;
  logic [DST_REG_W-1:0] dst_w_q, dst_h_q;
  logic                 smooth_q;

  // Effective sizes
  logic [SRC_REG_W-1:0] sw, sh;
  logic [DST_REG_W-1:0] dw, dh;
  logic                 is_copy;
  logic                 wr_ok;

  // Control
  state_e     state_q, state_d;
  corner_t    corner_q;
  logic       out_valid_q;
  logic       in_acc;
  logic       mem_en, mem_we;
  logic       div_start;
  logic       out_load;
  blend_ctl_t blend_ctl;

  // Datapath
  logic [DST_COORD_W-1:0] dx_q, dy_q;
  logic                   bil_q;
  logic [PX_W-1:0]        px_q, py_q;
  logic [SRC_REG_W-1:0]   x0_q, x1_q, y0_q, y1_q;
  logic [SRC_REG_W-1:0]   x0_c, y0_c;
  logic [FRAC_BITS-1:0]   fx_q, fy_q;
  logic [PIXEL_W-1:0]     res_q, out_pixel_q;
  logic [SRC_REG_W-1:0]   x_sel, y_sel;
  logic [AW-1:0]          mem_addr;
  logic [PIXEL_W-1:0]     mem_rdata;
  logic [PIXEL_W-1:0]     blend_pixel;
  logic [NUM_W-1:0]       num_x, num_y;
  logic [NUM_W-1:0]       quo_x, quo_y;
  logic                   div_done_x, div_done_y;
  logic                   div_pair_done;

  // Saturate the size registers, zero counts as one
  always_comb begin
    if (src_w_q == '0) begin
      sw = SRC_REG_W'(1);
    end else if (32'(src_w_q) > MAX_SRC_WIDTH) begin
      sw = SRC_REG_W'(MAX_SRC_WIDTH);
    end else begin
      sw = src_w_q;
    end
    if (src_h_q == '0) begin
      sh = SRC_REG_W'(1);
    end else if (32'(src_h_q) > MAX_SRC_HEIGHT) begin
      sh = SRC_REG_W'(MAX_SRC_HEIGHT);
    end else begin
      sh = src_h_q;
    end
    if (dst_w_q == '0) begin
      dw = DST_REG_W'(1);
    end else if (32'(dst_w_q) > MAX_DST_DIM) begin
      dw = DST_REG_W'(MAX_DST_DIM);
    end else begin
      dw = dst_w_q;
    end
    if (dst_h_q == '0) begin
      dh = DST_REG_W'(1);
    end else if (32'(dst_h_q) > MAX_DST_DIM) begin
      dh = DST_REG_W'(MAX_DST_DIM);
    end else begin
      dh = dst_h_q;
    end
    is_copy = (DST_REG_W'(sw) == dw) && (DST_REG_W'(sh) == dh);
    wr_ok   = (32'(src_x_i) < MAX_SRC_WIDTH) && (32'(src_y_i) < MAX_SRC_HEIGHT);
  end

  // Divider operands: step numerator for bilinear, dst_coord * src for nearest
  always_comb begin
    if (smooth_q) begin
      num_x = NUM_W'(sw - SRC_REG_W'(1)) << FRAC_BITS;
      num_y = NUM_W'(sh - SRC_REG_W'(1)) << FRAC_BITS;
    end else begin
      num_x = NUM_W'(dst_x_i) * NUM_W'(sw);
      num_y = NUM_W'(dst_y_i) * NUM_W'(sh);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && action_i == ACT_SAMPLE) begin
          state_d = is_copy ? ST_SINGLE_RD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_pair_done) begin
          state_d = bil_q ? ST_POS : ST_SINGLE_RD;
        end
      end
      ST_POS:        state_d = ST_COORD;
      ST_COORD:      state_d = ST_FETCH;
      ST_FETCH: begin
        if (corner_q == CORNER_BR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:      state_d = ST_PACK;
      ST_PACK:       state_d = ST_DONE;
      ST_SINGLE_RD:  state_d = ST_SINGLE_DAT;
      ST_SINGLE_DAT: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    in_acc           = in_valid_i && (state_q == ST_IDLE);
    mem_en           = 1'b0;
    mem_we           = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    blend_ctl        = '0;
    blend_ctl.corner = corner_q;
    x_sel            = x0_q;
    y_sel            = y0_q;
    case (state_q)
      ST_IDLE: begin
        x_sel     = SRC_REG_W'(src_x_i);
        y_sel     = SRC_REG_W'(src_y_i);
        mem_we    = 1'b1;
        mem_en    = in_acc && (action_i == ACT_WRITE) && wr_ok;
        div_start = in_acc && (action_i == ACT_SAMPLE) && !is_copy;
      end
      ST_COORD: begin
        blend_ctl.clear = 1'b1;
      end
      ST_FETCH: begin
        x_sel            = corner_q[0] ? x1_q : x0_q;
        y_sel            = corner_q[1] ? y1_q : y0_q;
        mem_en           = 1'b1;
        blend_ctl.wload  = 1'b1;
        blend_ctl.acc_en = (corner_q != CORNER_TL);
      end
      ST_DRAIN: begin
        blend_ctl.acc_en = 1'b1;
      end
      ST_SINGLE_RD: begin
        mem_en = 1'b1;
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
    mem_addr = AW'(y_sel) * AW'(MAX_SRC_WIDTH) + AW'(x_sel);
  end

  // Bilinear integer coordinates, clamped to the source size
  always_comb begin
    x0_c = clamp_coord(px_q[PX_W-1:FRAC_BITS], sw);
    y0_c = clamp_coord(py_q[PX_W-1:FRAC_BITS], sh);
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      corner_q    <= CORNER_TL;
      out_valid_q <= 1'b0;
      src_w_q     <= SRC_REG_W'(256);
      src_h_q     <= SRC_REG_W'(256);
      dst_w_q     <= DST_REG_W'(256);
      dst_h_q     <= DST_REG_W'(256);
      smooth_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_COORD) begin
        corner_q <= CORNER_TL;
      end else if (state_q == ST_FETCH) begin
        corner_q <= corner_q + corner_t'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_w_q  <= cfg_wdata_i[SRC_REG_W-1:0];
          REG_SRC_HEIGHT: src_h_q  <= cfg_wdata_i[SRC_REG_W-1:0];
          REG_DST_WIDTH:  dst_w_q  <= cfg_wdata_i[DST_REG_W-1:0];
          REG_DST_HEIGHT: dst_h_q  <= cfg_wdata_i[DST_REG_W-1:0];
          REG_SMOOTHING:  smooth_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // Coordinate and result datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dx_q  <= dst_x_i;
          dy_q  <= dst_y_i;
          bil_q <= smooth_q;
          x0_q  <= clamp_coord(PI_W'(dst_x_i), sw);
          y0_q  <= clamp_coord(PI_W'(dst_y_i), sh);
        end
      end
      ST_DIV: begin
        if (div_pair_done && !bil_q) begin
          x0_q <= clamp_coord(PI_W'(quo_x), sw);
          y0_q <= clamp_coord(PI_W'(quo_y), sh);
        end
      end
      ST_POS: begin
        px_q <= PX_W'(quo_x) * PX_W'(dx_q);
        py_q <= PX_W'(quo_y) * PX_W'(dy_q);
      end
      ST_COORD: begin
        x0_q <= x0_c;
        y0_q <= y0_c;
        x1_q <= (x0_c == sw - SRC_REG_W'(1)) ? x0_c : x0_c + SRC_REG_W'(1);
        y1_q <= (y0_c == sh - SRC_REG_W'(1)) ? y0_c : y0_c + SRC_REG_W'(1);
        fx_q <= px_q[FRAC_BITS-1:0];
        fy_q <= py_q[FRAC_BITS-1:0];
      end
      ST_PACK:       res_q <= blend_pixel;
      ST_SINGLE_DAT: res_q <= mem_rdata;
      default: ;
    endcase
    if (out_load) begin
      out_pixel_q <= res_q;
    end
  end

  bnis_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIXEL_W)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (src_pixel_i),
    .rdata_o (mem_rdata)
  );

  bnis_div #(
    .NUM_W (NUM_W),
    .DEN_W (DST_REG_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (dw),
    .done_o  (div_done_x),
    .quo_o   (quo_x)
  );

  bnis_div #(
    .NUM_W (NUM_W),
    .DEN_W (DST_REG_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (dh),
    .done_o  (div_done_y),
    .quo_o   (quo_y)
  );

  bnis_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .ctl_i   (blend_ctl),
    .fx_i    (fx_q),
    .fy_i    (fy_q),
    .pixel_i (mem_rdata),
    .pixel_o (blend_pixel)
  );

  // Both dividers run in lockstep; advance once the pair is done
  assign div_pair_done = div_done_x & div_done_y;

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

endmodule

`default_nettype wire
